>>> rtl/kvls_pkg.sv
// Shared types, codes and constants of the key/value line splitter.
package kvls_pkg;

    localparam int LINE_MAX_DEFAULT = 4096;
    localparam int QUEUE_DEPTH      = 4;
    localparam int CHAR_W           = 8;
    localparam int FIELD_W          = 12;
    localparam int M_DATA_W         = 56;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [CHAR_W-1:0] DELIMITER_RESET = 8'd61;
    localparam logic              TRIM_RESET      = 1'b1;

    // configuration register indexes
    localparam logic CFG_DELIMITER = 1'b0;
    localparam logic CFG_TRIM      = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPLIT = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // classified character, front to back
    typedef struct packed {
        logic zero;    // NUL byte, ends the text
        logic delim;   // matches the delimiter
        logic lead;    // space or tab
        logic tail;    // space, tab or CR
        logic last;    // final byte of the line
    } cls_t;

endpackage

>>> rtl/kvls_front.sv
// Front part: classify incoming characters and queue them for the back part.
module kvls_front
    import kvls_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic [CHAR_W-1:0] delimiter_char,
    output logic              q_valid,
    output cls_t              q_item,
    input  logic              q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    cls_t             item_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cls_t             cls;
    logic             push, pop;

    always_comb begin
        cls.zero  = (s_tdata == CH_NUL);
        cls.delim = (s_tdata == delimiter_char);
        cls.lead  = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
        cls.tail  = cls.lead || (s_tdata == CH_CR);
        cls.last  = s_tlast;
    end

    assign s_tready = (count_reg != DEPTH_C);
    assign q_valid  = (count_reg != '0);
    assign q_item   = item_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg[wr_ptr_reg] <= cls;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue fill count beyond depth");
`endif

endmodule

>>> rtl/kvls_back.sv
// Back part: track line state per character and capture a snapshot at line end.
module kvls_back
    import kvls_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    input  cls_t q_item,
    output logic q_pop,
    output logic snap_valid,
    output logic [6*$clog2(LINE_MAX)+6-1:0] snap_bits,
    input  logic snap_take
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int PW = $clog2(LINE_MAX + 1);
    localparam logic [PW-1:0] CAP  = PW'(LINE_MAX - 1);
    localparam logic [PW-1:0] LMAX = PW'(LINE_MAX);

    typedef struct packed {
        logic          over;
        logic          split_seen;
        logic [AW-1:0] d;
        logic [AW-1:0] len;
        logic          fn_v;
        logic [AW-1:0] fn;
        logic          kl_v;
        logic [AW-1:0] kl;
        logic          vf_v;
        logic [AW-1:0] vf;
        logic          vl_v;
        logic [AW-1:0] vl;
    } snap_t;

    typedef struct packed {
        logic [PW-1:0] pos;
        logic          split_seen;
        logic [AW-1:0] d;
        logic          fn_v;
        logic [AW-1:0] fn;
        logic          ln_v;
        logic [AW-1:0] ln;
        logic          kl_v;
        logic [AW-1:0] kl;
        logic          vf_v;
        logic [AW-1:0] vf;
        logic          vl_v;
        logic [AW-1:0] vl;
        logic          stopped;
    } line_t;

    line_t         line_reg, upd;
    snap_t         snap_reg, snap_next;
    logic          snap_vld_reg;
    logic          fire;
    logic [AW-1:0] p;

    assign q_pop      = q_valid && (!q_item.last || !snap_vld_reg || snap_take);
    assign fire       = q_pop;
    assign snap_valid = snap_vld_reg;
    assign snap_bits  = snap_reg;
    assign p          = line_reg.pos[AW-1:0];

    always_comb begin
        upd = line_reg;
        if (!line_reg.stopped) begin
            if (q_item.zero) begin
                upd.stopped = 1'b1;
            end else if (line_reg.pos >= CAP) begin
                upd.pos = LMAX;
            end else begin
                if (q_item.delim) begin
                    upd.split_seen = 1'b1;
                    upd.d          = p;
                    upd.kl_v       = line_reg.ln_v;
                    upd.kl         = line_reg.ln;
                    upd.vf_v       = 1'b0;
                    upd.vl_v       = 1'b0;
                end else begin
                    if (!q_item.lead && !line_reg.vf_v) begin
                        upd.vf_v = 1'b1;
                        upd.vf   = p;
                    end
                    if (!q_item.tail) begin
                        upd.vl_v = 1'b1;
                        upd.vl   = p;
                    end
                end
                if (!q_item.lead && !line_reg.fn_v) begin
                    upd.fn_v = 1'b1;
                    upd.fn   = p;
                end
                if (!q_item.tail) begin
                    upd.ln_v = 1'b1;
                    upd.ln   = p;
                end
                upd.pos = line_reg.pos + 1'b1;
            end
        end
    end

    always_comb begin
        snap_next.over       = (upd.pos > CAP);
        snap_next.split_seen = upd.split_seen;
        snap_next.d          = upd.d;
        snap_next.len        = snap_next.over ? CAP[AW-1:0] : upd.pos[AW-1:0];
        snap_next.fn_v       = upd.fn_v;
        snap_next.fn         = upd.fn;
        snap_next.kl_v       = upd.kl_v;
        snap_next.kl         = upd.kl;
        snap_next.vf_v       = upd.vf_v;
        snap_next.vf         = upd.vf;
        snap_next.vl_v       = upd.vl_v;
        snap_next.vl         = upd.vl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && q_item.last)) begin
            line_reg            <= '0;
        end else if (fire) begin
            line_reg            <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_vld_reg <= 1'b0;
        end else if (fire && q_item.last) begin
            snap_vld_reg <= 1'b1;
        end else if (snap_take) begin
            snap_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && q_item.last) begin
            snap_reg <= snap_next;
        end
    end

`ifndef ASSERT_OFF
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg.pos <= LMAX)
        else $error("line position beyond limit");

    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_vld_reg && !snap_take |=> snap_vld_reg && $stable(snap_reg))
        else $error("line snapshot lost before it was taken");
`endif

endmodule

>>> rtl/kvls_result.sv
// Result stage: apply trimming to the line snapshot and hold the result request.
module kvls_result
    import kvls_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                trim_enable,
    input  logic                snap_valid,
    input  logic [6*$clog2(LINE_MAX)+6-1:0] snap_bits,
    output logic                snap_take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int EW = (AW > FIELD_W) ? AW : FIELD_W;

    typedef struct packed {
        logic          over;
        logic          split_seen;
        logic [AW-1:0] d;
        logic [AW-1:0] len;
        logic          fn_v;
        logic [AW-1:0] fn;
        logic          kl_v;
        logic [AW-1:0] kl;
        logic          vf_v;
        logic [AW-1:0] vf;
        logic          vl_v;
        logic [AW-1:0] vl;
    } snap_t;

    snap_t         sn;
    logic          ok;
    logic [AW-1:0] ks, ke, vs, ve, klen, vlen;
    logic [EW-1:0] ks_x, klen_x, vs_x, vlen_x;
    status_t       status;
    logic          m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign sn        = snap_bits;
    assign snap_take = snap_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        ok = sn.split_seen && !((sn.d == '0) && (sn.len == AW'(1)));
        ks = '0;
        ke = '0;
        vs = '0;
        ve = '0;
        if (ok) begin
            if (trim_enable) begin
                ks = (sn.fn_v && (sn.fn < sn.d)) ? sn.fn : sn.d;
                ke = sn.kl_v ? sn.kl + 1'b1 : ks;
                vs = sn.vf_v ? sn.vf : sn.len;
                ve = sn.vl_v ? sn.vl + 1'b1 : vs;
            end else begin
                ks = '0;
                ke = sn.d;
                vs = sn.d + 1'b1;
                ve = sn.len;
            end
        end
        klen   = ke - ks;
        vlen   = ve - vs;
        ks_x   = EW'(ks);
        klen_x = EW'(klen);
        vs_x   = EW'(vs);
        vlen_x = EW'(vlen);
        status = sn.over ? ST_TOO_LONG : (ok ? ST_OK : ST_NO_SPLIT);
        m_tdata_next = {6'd0, vlen_x[FIELD_W-1:0], vs_x[FIELD_W-1:0],
                        klen_x[FIELD_W-1:0], ks_x[FIELD_W-1:0], status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (snap_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_take) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef ASSERT_OFF
    a_nosplit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_tdata_reg[1:0] == ST_NO_SPLIT) |-> (m_tdata_reg[49:2] == '0))
        else $error("line without split reports nonzero offsets");
`endif

endmodule

>>> rtl/key_value_line_splitter.sv
// Top level of the key/value line splitter: config registers, front, back, result.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata[7:0] character, s_tlast last_char
//  m_       | out | m_tvalid/m_tready  | m_tdata status, key/value start and length
//  cfg_     | in  | cfg_we             | cfg_index register, cfg_data value
//
//  One character is taken per clock while the queue has room; each character is
//  registered in the classifier queue and then tracked by the line tracker; at its
//  last character a line snapshot is registered, and the result is held in the output register.
//  The four-entry queue decouples the input from the line tracker, so a stalled
//  result only backs up input once the queue and the snapshot stage are full.
//  aresetn is synchronous and active low; it restores the delimiter '=' and
//  trimming on, empties the queue and clears the line state. No clearing pass.
module key_value_line_splitter
    import kvls_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input character stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CHAR_W-1:0]   s_tdata,   // [7:0] character
    input  logic                s_tlast,   // last_char
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [1:0] status, [13:2] key_start,
                                           // [25:14] key_length, [37:26] value_start,
                                           // [49:38] value_length, [55:50] zero
    // configuration write port
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CHAR_W-1:0]   cfg_data
);

    localparam int AW     = $clog2(LINE_MAX);
    localparam int SNAP_W = 6*AW + 6;

    logic [CHAR_W-1:0] delimiter_reg;
    logic              trim_reg;
    logic              q_valid;
    cls_t              q_item;
    logic              q_pop;
    logic              snap_valid;
    logic [SNAP_W-1:0] snap_bits;
    logic              snap_take;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg <= DELIMITER_RESET;
            trim_reg      <= TRIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DELIMITER: delimiter_reg <= cfg_data;
                CFG_TRIM:      trim_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // classify each character against the delimiter and whitespace sets
    kvls_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .delimiter_char (delimiter_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    // advance line position, split and nonblank markers; snapshot at line end
    kvls_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .snap_valid (snap_valid),
        .snap_bits  (snap_bits),
        .snap_take  (snap_take)
    );

    // trim, compute offsets and lengths, hold the result request
    kvls_result #(
        .LINE_MAX (LINE_MAX)
    ) u_result (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .trim_enable (trim_reg),
        .snap_valid  (snap_valid),
        .snap_bits   (snap_bits),
        .snap_take   (snap_take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

>>> tb/sv/key_value_line_splitter_test.sv
// Self-checking testbench of the key/value line splitter: directed and random lines.
module key_value_line_splitter_test
    import kvls_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    // Far above the slowest correct run, with every stall phase.
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_CHARS  = 175;
    localparam int SETTLE_CYCLES = 8;

    // Line bookkeeping widths: 13 bits hold every offset up to LINE_MAX plus "none".
    localparam logic [12:0] CAPACITY  = 13'(LINE_MAX_DEFAULT - 1);
    localparam logic [12:0] LINE_FULL = 13'(LINE_MAX_DEFAULT);
    localparam logic [12:0] NONE      = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              eol;
    } line_char_t;

    typedef struct {
        status_t            status;
        logic [FIELD_W-1:0] key_start;
        logic [FIELD_W-1:0] key_length;
        logic [FIELD_W-1:0] value_start;
        logic [FIELD_W-1:0] value_length;
    } split_result_t;

    // DUT ports; the inputs that the bench drives are known from time zero
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_DELIMITER;
    logic [CHAR_W-1:0]   cfg_data  = '0;

    // stimulus and expectation stores
    line_char_t    char_q[$];      // characters not yet accepted by the block
    split_result_t split_q[$];     // predicted line results, oldest first
    logic [7:0]    line_buf[$];    // line under construction
    logic          char_taken = 1'b0;
    idle_t         idle_mode  = IDLE_NONE;

    // shadow of the block: registers and per-line state
    logic [7:0]  delim_cfg;
    logic        trim_cfg;
    logic [12:0] pos;
    logic        split_seen;
    logic [11:0] split_pos;
    logic [12:0] first_nb;
    logic [12:0] last_nb;
    logic [12:0] key_last_nb;
    logic [12:0] val_first_nb;
    logic [12:0] val_last_nb;
    logic        halted;

    // run statistics
    int n_chars;
    int n_lines;
    int n_results;
    int n_settings;
    int errors;
    int status_seen[3];

    key_value_line_splitter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------

    task automatic clear_line();
        pos          = '0;
        split_seen   = 1'b0;
        split_pos    = '0;
        first_nb     = NONE;
        last_nb      = NONE;
        key_last_nb  = NONE;
        val_first_nb = NONE;
        val_last_nb  = NONE;
        halted       = 1'b0;
    endtask

    // Advance the shadow line state by one character; at end of line queue the result.
    task automatic scan_char(input logic [7:0] ch, input logic eol);
        logic [12:0]   p;
        logic [12:0]   len;
        logic [12:0]   d;
        logic [12:0]   ks;
        logic [12:0]   ke;
        logic [12:0]   vs;
        logic [12:0]   ve;
        logic          lead;
        logic          tail;
        logic          over;
        logic          ok;
        split_result_t r;
        if (!halted) begin
            if (ch == CH_NUL) begin
                // a NUL ends the text; the rest of the line is ignored
                halted = 1'b1;
            end else if (pos >= CAPACITY) begin
                // drop bytes past the capacity, remember the overflow
                pos = LINE_FULL;
            end else begin
                p    = pos;
                lead = (ch == CH_SPACE) || (ch == CH_TAB);
                tail = lead || (ch == CH_CR);
                if (ch == delim_cfg) begin
                    // every delimiter restarts the value, so the last one splits
                    split_seen   = 1'b1;
                    split_pos    = p[11:0];
                    key_last_nb  = last_nb;
                    val_first_nb = NONE;
                    val_last_nb  = NONE;
                end else begin
                    if (!lead && val_first_nb == NONE)
                        val_first_nb = p;
                    if (!tail)
                        val_last_nb = p;
                end
                if (!lead && first_nb == NONE)
                    first_nb = p;
                if (!tail)
                    last_nb = p;
                pos = p + 13'd1;
            end
        end
        if (eol) begin
            over = pos > CAPACITY;
            len  = over ? CAPACITY : pos;
            d    = {1'b0, split_pos};
            // a line that is only the delimiter has nothing on either side
            ok   = split_seen && !(d == '0 && len == 13'd1);
            ks   = '0;
            ke   = '0;
            vs   = '0;
            ve   = '0;
            if (ok) begin
                if (trim_cfg) begin
                    ks = (first_nb != NONE && first_nb < d) ? first_nb : d;
                    ke = (key_last_nb != NONE) ? key_last_nb + 13'd1 : ks;
                    vs = (val_first_nb != NONE) ? val_first_nb : len;
                    ve = (val_last_nb != NONE) ? val_last_nb + 13'd1 : vs;
                end else begin
                    ks = '0;
                    ke = d;
                    vs = d + 13'd1;
                    ve = len;
                end
            end
            r.status       = over ? ST_TOO_LONG : (ok ? ST_OK : ST_NO_SPLIT);
            r.key_start    = ks[11:0];
            r.key_length   = 12'(ke - ks);
            r.value_start  = vs[11:0];
            r.value_length = 12'(ve - vs);
            split_q.push_back(r);
            clear_line();
        end
    endtask

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Compare one accepted result with the oldest prediction, field by field.
    task automatic check_split(input logic [M_DATA_W-1:0] word);
        split_result_t e;
        if (split_q.size() == 0) begin
            note_mismatch($sformatf("result %h with nothing expected", word));
        end else begin
            e = split_q.pop_front();
            n_results++;
            status_seen[e.status]++;
            if (word[1:0] !== e.status || word[13:2] !== e.key_start
                    || word[25:14] !== e.key_length || word[37:26] !== e.value_start
                    || word[49:38] !== e.value_length || word[55:50] !== '0)
                note_mismatch({
                    $sformatf("result %0d: expected st=%0d ks=%0d kl=%0d vs=%0d vl=%0d pad=0, ",
                        n_results, e.status, e.key_start, e.key_length, e.value_start,
                        e.value_length),
                    $sformatf("got st=%0d ks=%0d kl=%0d vs=%0d vl=%0d pad=%h",
                        word[1:0], word[13:2], word[25:14], word[37:26],
                        word[49:38], word[55:50])});
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            delim_cfg = DELIMITER_RESET;
            trim_cfg  = TRIM_RESET;
            clear_line();
            char_taken <= 1'b0;
        end else begin
            // mirror register writes at the edge that the block takes them
            if (cfg_we) begin
                if (cfg_index == CFG_DELIMITER)
                    delim_cfg = cfg_data;
                else if (cfg_index == CFG_TRIM)
                    trim_cfg = cfg_data[0];
            end
            char_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                scan_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_split(m_tdata);
        end
    end

    // Draw one idle decision for the sender or the receiver in the current phase.
    function automatic bit stall_draw(input bit recv_side);
        case (idle_mode)
            IDLE_SEND: return !recv_side && ($urandom_range(99) < 73);
            IDLE_RECV: return recv_side && ($urandom_range(99) < 73);
            IDLE_BOTH: return $urandom_range(99) < 20;
            default:   return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            // drop the request the block took at the last rising edge
            if (char_taken)
                void'(char_q.pop_front());
            if (s_tvalid && !char_taken) begin
                // hold a request that is still waiting for tready
            end else if (char_q.size() != 0 && !stall_draw(1'b0)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= char_q[0].ch;
                s_tlast  <= char_q[0].eol;
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= !stall_draw(1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_char(input logic [7:0] ch, input logic eol);
        line_char_t c;
        c.ch  = ch;
        c.eol = eol;
        char_q.push_back(c);
        n_chars++;
        if (eol)
            n_lines++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    // Flush the line under construction, last byte flagged.
    task automatic flush_line();
        for (int i = 0; i < line_buf.size(); i++)
            push_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic add_blanks(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(2);
            line_buf.push_back(r == 0 ? CH_SPACE : (r == 1 ? CH_TAB : CH_CR));
        end
    endtask

    // Append text that avoids the delimiter: mostly printable, some high bytes.
    task automatic add_word(input logic [7:0] dl, input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                c = 8'($urandom_range(8'hFF, 8'h80));
            else
                c = 8'($urandom_range(8'h7E, 8'h21));
            if (c == dl)
                c = (dl == "x") ? "y" : "x";
            line_buf.push_back(c);
        end
    endtask

    // Build one random line: mostly key/value shaped, the rest noise or broken.
    task automatic push_random_line(input logic [7:0] dl);
        int pick;
        int n;
        int cut;
        pick = $urandom_range(99);
        if (pick < 70) begin
            add_blanks($urandom_range(2));
            add_word(dl, $urandom_range(6));
            add_blanks($urandom_range(2));
            line_buf.push_back(dl);
            add_blanks($urandom_range(2));
            add_word(dl, $urandom_range(6));
            add_blanks($urandom_range(2));
        end else if (pick < 80) begin
            // several delimiters in a row or spread out
            n = $urandom_range(4, 2);
            for (int i = 0; i < n; i++) begin
                add_word(dl, $urandom_range(3));
                line_buf.push_back(dl);
            end
            add_word(dl, $urandom_range(3));
        end else if (pick < 90) begin
            n = $urandom_range(16, 1);
            for (int i = 0; i < n; i++)
                line_buf.push_back($urandom_range(3) == 0 ? dl : 8'($urandom_range(255)));
        end else begin
            // medium line, sometimes cut short by a NUL
            add_word(dl, $urandom_range(120, 20));
            line_buf.push_back(dl);
            add_word(dl, $urandom_range(120, 20));
            if ($urandom_range(1)) begin
                cut = $urandom_range(line_buf.size() - 1);
                line_buf.insert(cut, CH_NUL);
            end
        end
        if (line_buf.size() == 0)
            line_buf.push_back(dl);
        flush_line();
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every character is taken and every result checked, then settle.
    task automatic drain();
        while (char_q.size() != 0 || s_tvalid || split_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] dl;
        logic       tr;
        int         start;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed lines under the reset setting: '=' with trimming on
        idle_mode = IDLE_NONE;
        n_settings = 1;
        push_str("=");                 // only the delimiter
        push_str("ab");                // no split at all
        push_str(" a =\t b\r");        // blanks around both parts
        push_str("a==b");              // adjacent delimiters, last one splits
        push_str("k= \r");             // value left with only CR
        push_str(" =");                // key all blank, value empty
        push_char("a", 1'b0);          // NUL ends the text early
        push_char(CH_NUL, 1'b0);
        push_str("=b");
        push_char(CH_NUL, 1'b1);       // empty line
        push_char(8'hFF, 1'b1);        // top byte alone
        drain();

        // random phases, each under its own register setting and idle pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       begin dl = DELIMITER_RESET; tr = 1'b1; end
                1:       begin dl = DELIMITER_RESET; tr = 1'b0; end
                2:       begin dl = CH_NUL;          tr = 1'b1; end
                3:       begin dl = 8'hFF;           tr = 1'b0; end
                4:       begin dl = CH_SPACE;        tr = 1'b1; end
                5:       begin dl = CH_CR;           tr = 1'b1; end
                6:       begin dl = CH_TAB;          tr = 1'b0; end
                7:       begin dl = ":";             tr = 1'b1; end
                default: begin dl = 8'($urandom_range(255)); tr = 1'($urandom_range(1)); end
            endcase
            // upper data bits of the trim write carry noise that must be ignored
            write_reg(CFG_DELIMITER, dl);
            write_reg(CFG_TRIM, {7'($urandom_range(127)), tr});
            n_settings++;
            idle_mode = idle_t'(ph % 4);
            start = n_chars;
            while (n_chars - start < PHASE_CHARS)
                push_random_line(dl);
            drain();
        end

        repeat (20) @(negedge aclk);
        errors += split_q.size();
        $display("covered %0d lines (%0d characters) under %0d register settings",
                 n_lines, n_chars, n_settings);
        $display("results checked %0d: ok %0d, no split %0d, too long %0d; mismatches %0d",
                 n_results, status_seen[ST_OK], status_seen[ST_NO_SPLIT],
                 status_seen[ST_TOO_LONG], errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout: %0d characters pending, %0d results outstanding",
                 char_q.size(), split_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
